FILE: rtl/ilfe_pkg.sv
`default_nettype none

package ilfe_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned DELTA_W  = 5;
  localparam int unsigned ENERGY_W = 15;

  localparam int ENERGY_MIN_I = -16384;
  localparam int ENERGY_MAX_I = 16383;

  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = 15'sh4000;
  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 15'sh3FFF;

  typedef enum logic [OP_W-1:0] {
    OP_PROPOSE = 2'd0,
    OP_ACCEPT  = 2'd1,
    OP_REJECT  = 2'd2
  } op_e;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Energy add with 15-bit saturation.
  function automatic logic signed [ENERGY_W-1:0] energy_add(
    input logic signed [ENERGY_W-1:0] e,
    input logic signed [DELTA_W-1:0]  d
  );
    logic signed [ENERGY_W:0] s;
    s = $signed({e[ENERGY_W-1], e}) + (ENERGY_W+1)'(d);
    if (s > $signed({1'b0, ENERGY_MAX})) begin
      return ENERGY_MAX;
    end else if (s < $signed({1'b1, ENERGY_MIN})) begin
      return ENERGY_MIN;
    end
    return s[ENERGY_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ising_lattice_flip_energy.sv
`default_nettype none

// Periodic ROWS x COLS Ising lattice with single-spin-flip proposals. One word
// is taken per cycle while the output is accepted; the input edge reads the
// three lattice rows around the site from three row-wide RAM copies into the
// stage, and the output register then takes the result. A proposal is held as an
// overlay on the committed lattice; accept writes the flipped row back, reject
// drops the overlay and restores the committed energy. After reset a clearing
// pass writes every row to set every spin to +1, and no word is taken until it ends.
module ising_lattice_flip_energy
  import ilfe_pkg::*;
#(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [OP_W-1:0]            operation_i,
  input  wire logic [COORD_W-1:0]         site_x_i,
  input  wire logic [COORD_W-1:0]         site_y_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [DELTA_W-1:0]       delta_energy_o,
  output logic signed [ENERGY_W-1:0]      tentative_energy_o,
  output logic signed [ENERGY_W-1:0]      committed_energy_o,
  output logic                            status_o
);

  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLS);

  localparam int E0 = -2 * int'(ROWS) * int'(COLS);
  localparam logic signed [ENERGY_W-1:0] ENERGY_RST =
    (E0 < ENERGY_MIN_I) ? ENERGY_MIN : ENERGY_W'(E0);

  typedef enum logic [1:0] {
    PH_CLEAR = 2'b01,
    PH_RUN   = 2'b10
  } phase_e;

  // Reduce a coordinate modulo n by restoring subtraction.
  function automatic logic [COORD_W-1:0] wrap_coord(
    input logic [COORD_W-1:0] v,
    input int unsigned        n
  );
    logic [COORD_W-1:0] r;
    r = v;
    for (int k = COORD_W - 1; k >= 0; k--) begin
      if (32'(r) >= (n << k)) begin
        r = r - COORD_W'(n << k);
      end
    end
    return r;
  endfunction

  // Clearing pass
  phase_e        phase_q, phase_d;
  logic [RW-1:0] clr_addr_q, clr_addr_d;

  // Input side
  logic          in_fire;
  logic [RW-1:0] in_row, in_up, in_dn;
  logic [CW-1:0] in_col, in_lf, in_rt;

  // Stage register
  logic            st_valid_q, st_valid_d;
  logic [OP_W-1:0] st_op_q;
  logic [RW-1:0]   st_row_q, st_up_q, st_dn_q;
  logic [CW-1:0]   st_col_q, st_lf_q, st_rt_q;
  logic            st_fire;

  // RAM ports and write bypass
  logic            ram_we;
  logic [RW-1:0]   ram_waddr;
  logic [COLS-1:0] ram_wdata;
  logic [COLS-1:0] up_rdata, mid_rdata, dn_rdata;
  logic [COLS-1:0] up_row, mid_row, dn_row;
  logic            wr_valid_q;
  logic [RW-1:0]   wr_addr_q;
  logic [COLS-1:0] wr_data_q;

  // Lattice state
  logic signed [ENERGY_W-1:0] cur_q, cur_d, saved_q, saved_d;
  logic                       pend_q, pend_d;
  logic [RW-1:0]              px_q, px_d;
  logic [CW-1:0]              py_q, py_d;
  logic [COLS-1:0]            prow_q, prow_d;

  logic                      is_prop, is_acc, is_rej;
  logic                      old_spin;
  logic [2:0]                up_cnt;
  logic signed [DELTA_W-1:0] nb_sum, nb_dbl, delta;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic signed [DELTA_W-1:0] out_delta_q;
  logic signed [ENERGY_W-1:0] out_tent_q, out_comm_q;
  logic                      out_status_q;

  // ---------------------------------------------------------------- input
  assign st_fire    = st_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (phase_q == PH_RUN) && (!st_valid_q || st_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_row = RW'(wrap_coord(site_x_i, ROWS));
    in_col = CW'(wrap_coord(site_y_i, COLS));
    in_up  = (in_row == '0) ? RW'(ROWS - 1) : in_row - RW'(1);
    in_dn  = (in_row == RW'(ROWS - 1)) ? '0 : in_row + RW'(1);
    in_lf  = (in_col == '0) ? CW'(COLS - 1) : in_col - CW'(1);
    in_rt  = (in_col == CW'(COLS - 1)) ? '0 : in_col + CW'(1);
  end

  // ---------------------------------------------------------------- lattice RAMs
  always_comb begin
    if (phase_q == PH_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '1;
    end else begin
      ram_we    = st_fire && is_acc;
      ram_waddr = px_q;
      ram_wdata = prow_q ^ (COLS'(1) << py_q);
    end
  end

  ilfe_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_ram_up (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(in_up),
    .rdata_o(up_rdata)
  );

  ilfe_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_ram_mid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(in_row),
    .rdata_o(mid_rdata)
  );

  ilfe_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_ram_dn (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(in_dn),
    .rdata_o(dn_rdata)
  );

  // A read issued on the same edge as a write returns old data: forward it.
  always_comb begin
    up_row  = (wr_valid_q && wr_addr_q == st_up_q)  ? wr_data_q : up_rdata;
    mid_row = (wr_valid_q && wr_addr_q == st_row_q) ? wr_data_q : mid_rdata;
    dn_row  = (wr_valid_q && wr_addr_q == st_dn_q)  ? wr_data_q : dn_rdata;
  end

  // ---------------------------------------------------------------- stage logic
  always_comb begin
    is_prop = (st_op_q == OP_PROPOSE) && !pend_q;
    is_acc  = (st_op_q == OP_ACCEPT) && pend_q;
    is_rej  = (st_op_q == OP_REJECT) && pend_q;

    // The neighbors never coincide with the site, so committed spins serve.
    old_spin = mid_row[st_col_q];
    up_cnt   = 3'(up_row[st_col_q]) + 3'(dn_row[st_col_q])
             + 3'(mid_row[st_lf_q]) + 3'(mid_row[st_rt_q]);
    nb_sum   = $signed({1'b0, up_cnt, 1'b0}) - 5'sd4;
    nb_dbl   = $signed({nb_sum[3:0], 1'b0});
    delta    = old_spin ? nb_dbl : -nb_dbl;

    cur_d   = cur_q;
    saved_d = saved_q;
    pend_d  = pend_q;
    px_d    = px_q;
    py_d    = py_q;
    prow_d  = prow_q;
    if (st_fire) begin
      if (is_prop) begin
        cur_d  = energy_add(cur_q, delta);
        pend_d = 1'b1;
        px_d   = st_row_q;
        py_d   = st_col_q;
        prow_d = mid_row;
      end else if (is_acc) begin
        saved_d = cur_q;
        pend_d  = 1'b0;
      end else if (is_rej) begin
        cur_d  = saved_q;
        pend_d = 1'b0;
      end
    end
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (in_fire) begin
      st_valid_d = 1'b1;
    end else if (st_fire) begin
      st_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (st_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    phase_d    = phase_q;
    clr_addr_d = clr_addr_q;
    case (phase_q)
      PH_CLEAR: begin
        if (clr_addr_q == RW'(ROWS - 1)) begin
          phase_d = PH_RUN;
        end else begin
          clr_addr_d = clr_addr_q + RW'(1);
        end
      end
      PH_RUN: begin
        phase_d = PH_RUN;
      end
      default: begin
        phase_d = PH_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLEAR;
      clr_addr_q  <= '0;
      st_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_valid_q  <= 1'b0;
      cur_q       <= ENERGY_RST;
      saved_q     <= ENERGY_RST;
      pend_q      <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
    end else begin
      phase_q     <= phase_d;
      clr_addr_q  <= clr_addr_d;
      st_valid_q  <= st_valid_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      saved_q     <= saved_d;
      pend_q      <= pend_d;
      px_q        <= px_d;
      py_q        <= py_d;
      // Track the write that lands on the same edge as the RAM read.
      if (in_fire) begin
        wr_valid_q <= ram_we;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prow_q <= prow_d;
    if (in_fire) begin
      st_op_q   <= operation_i;
      st_row_q  <= in_row;
      st_up_q   <= in_up;
      st_dn_q   <= in_dn;
      st_col_q  <= in_col;
      st_lf_q   <= in_lf;
      st_rt_q   <= in_rt;
      wr_addr_q <= ram_waddr;
      wr_data_q <= ram_wdata;
    end
    if (st_fire) begin
      out_delta_q  <= is_prop ? delta : '0;
      out_tent_q   <= cur_d;
      out_comm_q   <= saved_d;
      out_status_q <= (is_prop || is_acc || is_rej) ? STATUS_DONE : STATUS_REFUSED;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign delta_energy_o     = out_delta_q;
  assign tentative_energy_o = out_tent_q;
  assign committed_energy_o = out_comm_q;
  assign status_o           = out_status_q;

  // ---------------------------------------------------------------- assertions
  a_write_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && phase_q == PH_RUN) |-> pend_q)
    else $error("lattice row written with no pending flip");

  a_propose_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_fire && is_prop) |=> (pend_q && cur_q == $past(cur_d)))
    else $error("propose did not leave a pending flip");

  a_idle_energy_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> (cur_q == saved_q))
    else $error("tentative and committed energy differ with nothing pending");

  a_delta_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && delta_energy_o != '0) |-> (status_o == STATUS_DONE))
    else $error("nonzero energy change on a refused word");

endmodule

`default_nettype wire

FILE: rtl/ilfe_ram.sv
`default_nettype none

module ilfe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
